### rtl/core/fra_pkg.sv
// fraction reduce package: micro-op codes, jump conditions, step map and control ROM
`timescale 1ns / 1ps

package fra_pkg;

    // operation codes carried by the mode field
    localparam logic [1:0] MODE_ADD = 2'd0;
    localparam logic [1:0] MODE_SUB = 2'd1;
    localparam logic [1:0] MODE_MUL = 2'd2;
    localparam logic [1:0] MODE_DIV = 2'd3;

    // datapath micro-operations
    typedef enum logic [3:0] {
        OP_NOP,
        OP_LOAD,
        OP_MUL_T1,
        OP_ACC_SET,
        OP_ACC_ADD,
        OP_MAG,
        OP_GCD_K,
        OP_GCD_STEP,
        OP_GCD_G,
        OP_DIV_STEP,
        OP_DIV_NEXT,
        OP_OUT_RES,
        OP_OUT_ERR,
        OP_OUT_ZERO
    } uop_t;

    // jump conditions tested by the sequencer
    typedef enum logic [3:0] {
        C_NEVER,
        C_ALWAYS,
        C_NO_START,
        C_BAD,
        C_ACC_ZERO,
        C_BOTH_EVEN,
        C_GCD_NE,
        C_DIV_MORE,
        C_OUT_BUSY
    } cond_t;

    typedef logic [4:0] step_t;

    // step addresses of the control program
    localparam step_t S_IDLE  = 5'd0;
    localparam step_t S_CHECK = 5'd1;
    localparam step_t S_MUL1  = 5'd2;
    localparam step_t S_MUL2  = 5'd3;
    localparam step_t S_MUL3  = 5'd4;
    localparam step_t S_MAG   = 5'd5;
    localparam step_t S_KLOOP = 5'd6;
    localparam step_t S_GLOOP = 5'd7;
    localparam step_t S_GSET  = 5'd8;
    localparam step_t S_DIVN  = 5'd9;
    localparam step_t S_DNEXT = 5'd10;
    localparam step_t S_DIVD  = 5'd11;
    localparam step_t S_RES   = 5'd12;
    localparam step_t S_RRET  = 5'd13;
    localparam step_t S_ERR   = 5'd14;
    localparam step_t S_ERET  = 5'd15;
    localparam step_t S_ZERO  = 5'd16;
    localparam step_t S_ZRET  = 5'd17;
    localparam step_t S_LAST  = 5'd17;

    typedef struct packed {
        uop_t  op;
        cond_t cond;
        step_t target;
    } ucode_t;

    // status flags from datapath to sequencer
    typedef struct packed {
        logic bad;
        logic acc_zero;
        logic both_even;
        logic gcd_ne;
        logic div_last;
        logic out_busy;
    } flags_t;

    // control program, one word per step
    function automatic ucode_t ucode_rom(step_t pc);
        ucode_t w;
        case (pc)
            S_IDLE:  w = '{OP_LOAD,      C_NO_START,  S_IDLE};
            S_CHECK: w = '{OP_NOP,       C_BAD,       S_ERR};
            S_MUL1:  w = '{OP_MUL_T1,    C_NEVER,     S_IDLE};
            S_MUL2:  w = '{OP_ACC_SET,   C_NEVER,     S_IDLE};
            S_MUL3:  w = '{OP_ACC_ADD,   C_NEVER,     S_IDLE};
            S_MAG:   w = '{OP_MAG,       C_ACC_ZERO,  S_ZERO};
            S_KLOOP: w = '{OP_GCD_K,     C_BOTH_EVEN, S_KLOOP};
            S_GLOOP: w = '{OP_GCD_STEP,  C_GCD_NE,    S_GLOOP};
            S_GSET:  w = '{OP_GCD_G,     C_NEVER,     S_IDLE};
            S_DIVN:  w = '{OP_DIV_STEP,  C_DIV_MORE,  S_DIVN};
            S_DNEXT: w = '{OP_DIV_NEXT,  C_NEVER,     S_IDLE};
            S_DIVD:  w = '{OP_DIV_STEP,  C_DIV_MORE,  S_DIVD};
            S_RES:   w = '{OP_OUT_RES,   C_OUT_BUSY,  S_RES};
            S_RRET:  w = '{OP_NOP,       C_ALWAYS,    S_IDLE};
            S_ERR:   w = '{OP_OUT_ERR,   C_OUT_BUSY,  S_ERR};
            S_ERET:  w = '{OP_NOP,       C_ALWAYS,    S_IDLE};
            S_ZERO:  w = '{OP_OUT_ZERO,  C_OUT_BUSY,  S_ZERO};
            S_ZRET:  w = '{OP_NOP,       C_ALWAYS,    S_IDLE};
            default: w = '{OP_NOP,       C_ALWAYS,    S_IDLE};
        endcase
        return w;
    endfunction

endpackage

### rtl/core/fra_sequencer.sv
// fraction reduce sequencer: step counter, control ROM and conditional jumps
`timescale 1ns / 1ps

module fra_sequencer
    import fra_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   in_valid,
    input  flags_t flags,
    output logic   in_stall,
    output uop_t   uop
);

    step_t  pc_reg;
    step_t  pc_next;
    ucode_t word;
    logic   take;

    assign word = ucode_rom(pc_reg);

    // jump condition select
    always_comb
    begin
        case (word.cond)
            C_NEVER:     take = 1'b0;
            C_ALWAYS:    take = 1'b1;
            C_NO_START:  take = !in_valid;
            C_BAD:       take = flags.bad;
            C_ACC_ZERO:  take = flags.acc_zero;
            C_BOTH_EVEN: take = flags.both_even;
            C_GCD_NE:    take = flags.gcd_ne;
            C_DIV_MORE:  take = !flags.div_last;
            C_OUT_BUSY:  take = flags.out_busy;
            default:     take = 1'b1;
        endcase
    end

    // next step
    always_comb
    begin
        if (take)
        begin
            pc_next = word.target;
        end
        else
        begin
            pc_next = pc_reg + 5'd1;
        end
    end

    // control outputs
    always_comb
    begin
        uop      = word.op;
        in_stall = (pc_reg != S_IDLE);
    end

    // step counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg <= S_IDLE;
        end
        else
        begin
            pc_reg <= pc_next;
        end
    end

`ifndef SYNTH
    // program never runs past its last step
    a_pc_range: assert property (@(posedge clk) disable iff (!rst_n)
        pc_reg <= S_LAST)
        else $error("sequencer step out of range");

    // an accepted beat starts the program
    a_start: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> (pc_reg == S_CHECK))
        else $error("accepted beat did not start the program");
`endif

endmodule

### rtl/core/fra_datapath.sv
// fraction reduce datapath: multiplier, accumulator, binary gcd, restoring divider, result register
`timescale 1ns / 1ps

module fra_datapath
    import fra_pkg::*;
#(
    parameter int OPERAND_WIDTH = 16
)
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            load,
    input  uop_t                            uop,
    input  logic [1:0]                      mode,
    input  logic signed [OPERAND_WIDTH-1:0] num_a,
    input  logic signed [OPERAND_WIDTH-1:0] den_a,
    input  logic signed [OPERAND_WIDTH-1:0] num_b,
    input  logic signed [OPERAND_WIDTH-1:0] den_b,
    output flags_t                          flags,
    input  logic                            out_stall,
    output logic                            out_valid,
    output logic signed [31:0]              res_num,
    output logic [31:0]                     res_den,
    output logic                            err
);

    localparam int OW = OPERAND_WIDTH;
    localparam int PW = 2 * OW;
    localparam int AW = 2 * OW + 1;
    localparam int MW = 2 * OW;
    localparam int CW = $clog2(MW);
    localparam int XW = (MW > 32) ? MW : 32;

    // operand registers
    logic [1:0]           mode_reg;
    logic signed [OW-1:0] na_reg, da_reg, nb_reg, db_reg;

    // product and accumulator
    logic signed [OW-1:0] mul_x, mul_y;
    logic signed [PW-1:0] prod_reg;
    logic signed [AW-1:0] acc_reg;
    logic signed [AW-1:0] acc_abs;
    logic signed [PW-1:0] prod_abs;

    // gcd and divider state
    logic [MW-1:0] un_reg, ud_reg;
    logic          neg_reg;
    logic [MW-1:0] a_reg, b_reg;
    logic [CW-1:0] k_reg;
    logic [MW-1:0] dvs_reg, rem_reg, quo_reg, qn_reg;
    logic [CW-1:0] cnt_reg;
    logic [MW:0]   trial;

    // result register
    logic                     out_valid_reg;
    logic signed [31:0]       res_num_reg;
    logic [31:0]              res_den_reg;
    logic                     err_reg;
    logic [XW-1:0]            qn_x, qn_s, den_x;
    logic                     out_free;

    // multiplier operand select
    always_comb
    begin
        case (uop)
            OP_MUL_T1:
            begin
                mul_x = na_reg;
                mul_y = (mode_reg == MODE_MUL) ? nb_reg : db_reg;
            end
            OP_ACC_SET:
            begin
                mul_x = nb_reg;
                mul_y = da_reg;
            end
            OP_ACC_ADD:
            begin
                mul_x = da_reg;
                mul_y = (mode_reg == MODE_DIV) ? nb_reg : db_reg;
            end
            default:
            begin
                mul_x = na_reg;
                mul_y = db_reg;
            end
        endcase
    end

    // magnitudes and divider trial subtract
    assign acc_abs  = acc_reg[AW-1] ? -acc_reg : acc_reg;
    assign prod_abs = prod_reg[PW-1] ? -prod_reg : prod_reg;
    assign trial    = {rem_reg, quo_reg[MW-1]} - {1'b0, dvs_reg};

    // result forming
    assign qn_x     = XW'(qn_reg);
    assign qn_s     = neg_reg ? -qn_x : qn_x;
    assign den_x    = XW'(quo_reg);
    assign out_free = !(out_valid_reg && out_stall);

    // status flags
    always_comb
    begin
        flags.bad       = (da_reg == '0) || (db_reg == '0) ||
                          ((mode_reg == MODE_DIV) && (nb_reg == '0));
        flags.acc_zero  = (acc_reg == '0);
        flags.both_even = !a_reg[0] && !b_reg[0];
        flags.gcd_ne    = (a_reg != b_reg);
        flags.div_last  = (cnt_reg == CW'(MW - 1));
        flags.out_busy  = !out_free;
    end

    // working registers
    always_ff @(posedge clk)
    begin
        case (uop)
            OP_LOAD:
            begin
                if (load)
                begin
                    mode_reg <= mode;
                    na_reg   <= num_a;
                    da_reg   <= den_a;
                    nb_reg   <= num_b;
                    db_reg   <= den_b;
                end
            end
            OP_MUL_T1:
            begin
                prod_reg <= PW'(mul_x) * PW'(mul_y);
            end
            OP_ACC_SET:
            begin
                acc_reg  <= AW'(prod_reg);
                prod_reg <= PW'(mul_x) * PW'(mul_y);
            end
            OP_ACC_ADD:
            begin
                if (mode_reg == MODE_ADD)
                begin
                    acc_reg <= acc_reg + AW'(prod_reg);
                end
                else if (mode_reg == MODE_SUB)
                begin
                    acc_reg <= acc_reg - AW'(prod_reg);
                end
                prod_reg <= PW'(mul_x) * PW'(mul_y);
            end
            OP_MAG:
            begin
                un_reg  <= acc_abs[MW-1:0];
                ud_reg  <= prod_abs[MW-1:0];
                a_reg   <= acc_abs[MW-1:0];
                b_reg   <= prod_abs[MW-1:0];
                neg_reg <= acc_reg[AW-1] ^ prod_reg[PW-1];
                k_reg   <= '0;
            end
            OP_GCD_K:
            begin
                // strip common factors of two
                if (!a_reg[0] && !b_reg[0])
                begin
                    a_reg <= a_reg >> 1;
                    b_reg <= b_reg >> 1;
                    k_reg <= k_reg + CW'(1);
                end
            end
            OP_GCD_STEP:
            begin
                // binary gcd step, one operand changes
                if (a_reg != b_reg)
                begin
                    if (!a_reg[0])
                    begin
                        a_reg <= a_reg >> 1;
                    end
                    else if (!b_reg[0])
                    begin
                        b_reg <= b_reg >> 1;
                    end
                    else if (a_reg > b_reg)
                    begin
                        a_reg <= a_reg - b_reg;
                    end
                    else
                    begin
                        b_reg <= b_reg - a_reg;
                    end
                end
            end
            OP_GCD_G:
            begin
                dvs_reg <= a_reg << k_reg;
                quo_reg <= un_reg;
                rem_reg <= '0;
                cnt_reg <= '0;
            end
            OP_DIV_STEP:
            begin
                // restoring division, one quotient bit per cycle
                if (!trial[MW])
                begin
                    rem_reg <= trial[MW-1:0];
                    quo_reg <= {quo_reg[MW-2:0], 1'b1};
                end
                else
                begin
                    rem_reg <= {rem_reg[MW-2:0], quo_reg[MW-1]};
                    quo_reg <= {quo_reg[MW-2:0], 1'b0};
                end
                cnt_reg <= cnt_reg + CW'(1);
            end
            OP_DIV_NEXT:
            begin
                qn_reg  <= quo_reg;
                quo_reg <= ud_reg;
                rem_reg <= '0;
                cnt_reg <= '0;
            end
            default:
            begin
            end
        endcase
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (out_free)
        begin
            case (uop)
                OP_OUT_RES:
                begin
                    res_num_reg <= qn_s[31:0];
                    res_den_reg <= den_x[31:0];
                    err_reg     <= 1'b0;
                end
                OP_OUT_ERR:
                begin
                    res_num_reg <= '0;
                    res_den_reg <= '0;
                    err_reg     <= 1'b1;
                end
                OP_OUT_ZERO:
                begin
                    res_num_reg <= '0;
                    res_den_reg <= 32'd1;
                    err_reg     <= 1'b0;
                end
                default:
                begin
                end
            endcase
        end
    end

    // result valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_free && ((uop == OP_OUT_RES) || (uop == OP_OUT_ERR) ||
                              (uop == OP_OUT_ZERO)))
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_valid_reg && !out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    assign out_valid = out_valid_reg;
    assign res_num   = res_num_reg;
    assign res_den   = res_den_reg;
    assign err       = err_reg;

`ifndef SYNTH
    // gcd operands stay nonzero while reducing
    a_gcd_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (uop == OP_GCD_STEP) |-> ((a_reg != '0) && (b_reg != '0)))
        else $error("gcd operand reached zero");

    // divider remainder stays below the divisor
    a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (uop == OP_DIV_STEP) |-> (rem_reg < dvs_reg))
        else $error("divider remainder not below divisor");

    // an error beat carries a zero fraction
    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && err_reg) |-> ((res_den_reg == '0) && (res_num_reg == '0)))
        else $error("error beat with nonzero fraction");
`endif

endmodule

### rtl/core/fraction_arith_reduce.sv
// fraction reduce top level: fraction add/sub/mul/div with gcd reduction
`timescale 1ns / 1ps
//
//  channel | handshake            | payload
//  --------+----------------------+------------------------------------------
//  input   | in_valid, in_stall   | mode, num_a, den_a, num_b, den_b
//  output  | out_valid, out_stall | res_num, res_den, err
//
//  one beat at a time; the time a beat takes depends on k, the common factors of two,
//  and s, the binary gcd steps; the restoring divider works on MW = 2*OPERAND_WIDTH
//  bits (one quotient bit per cycle) and, with the gcd loop, sets the time of a beat
//  an error beat skips the arithmetic, and a zero result beat skips the gcd and divider
//  reset clears the step counter and the result valid; no clearing pass
//  a held result does not block the next input beat; the program waits only at its
//  output step while the previous result is still stalled
//

module fraction_arith_reduce
    import fra_pkg::*;
#(
    parameter int OPERAND_WIDTH = 16
)
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic [1:0]                      mode,
    input  logic signed [OPERAND_WIDTH-1:0] num_a,
    input  logic signed [OPERAND_WIDTH-1:0] den_a,
    input  logic signed [OPERAND_WIDTH-1:0] num_b,
    input  logic signed [OPERAND_WIDTH-1:0] den_b,
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic signed [31:0]              res_num,
    output logic [31:0]                     res_den,
    output logic                            err
);

    flags_t flags;
    uop_t   uop;
    logic   load;

    // input beat accepted
    assign load = in_valid && !in_stall;

    // control program
    fra_sequencer u_seq (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .flags    (flags),
        .in_stall (in_stall),
        .uop      (uop)
    );

    // arithmetic datapath
    fra_datapath #(
        .OPERAND_WIDTH (OPERAND_WIDTH)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (load),
        .uop       (uop),
        .mode      (mode),
        .num_a     (num_a),
        .den_a     (den_a),
        .num_b     (num_b),
        .den_b     (den_b),
        .flags     (flags),
        .out_stall (out_stall),
        .out_valid (out_valid),
        .res_num   (res_num),
        .res_den   (res_den),
        .err       (err)
    );

endmodule

### tb/sv/tb_fraction_arith_reduce.sv
// testbench for fraction_arith_reduce: self-checking fraction arithmetic with gcd reduction
`timescale 1ns / 1ps

module tb_fraction_arith_reduce;
    import fra_pkg::*;

    localparam int OPW       = 16;
    localparam int MAX_OP    = 2 ** (OPW - 1) - 1;
    localparam int MIN_OP    = -(2 ** (OPW - 1));
    localparam int LONG_HOLD = 400;
    localparam int TAIL_WAIT = 200;

    typedef struct {
        logic [1:0]            mode;
        logic signed [OPW-1:0] num_a;
        logic signed [OPW-1:0] den_a;
        logic signed [OPW-1:0] num_b;
        logic signed [OPW-1:0] den_b;
    } frac_op_t;

    typedef struct {
        logic signed [31:0] num;
        logic [31:0]        den;
        logic               err;
    } frac_res_t;

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  in_valid  = 1'b0;
    logic                  in_stall;
    logic [1:0]            mode      = MODE_ADD;
    logic signed [OPW-1:0] num_a     = '0;
    logic signed [OPW-1:0] den_a     = '0;
    logic signed [OPW-1:0] num_b     = '0;
    logic signed [OPW-1:0] den_b     = '0;
    logic                  out_valid;
    logic                  out_stall = 1'b0;
    logic signed [31:0]    res_num;
    logic [31:0]           res_den;
    logic                  err;

    // operations waiting to be driven and reduced fractions waiting to come out
    frac_op_t  pending_ops[$];
    frac_res_t reduced_q[$];
    frac_op_t  next_op;
    frac_res_t want;

    int  gap_left     = 0;
    int  hold_left    = 0;
    int  holds_asked  = 0;
    int  holds_served = 0;
    int  mismatches   = 0;
    bit  calm         = 1'b0;

    fraction_arith_reduce #(
        .OPERAND_WIDTH(OPW)
    ) u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .mode      (mode),
        .num_a     (num_a),
        .den_a     (den_a),
        .num_b     (num_b),
        .den_b     (den_b),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .res_num   (res_num),
        .res_den   (res_den),
        .err       (err)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // exact fraction result: cross multiply, reduce by gcd, sign on the numerator
    function automatic frac_res_t reduce_fraction(frac_op_t op);
        frac_res_t          r;
        longint             na, da, nb, db, n, d;
        longint unsigned    un, ud, x, y, t, qn, qd;
        bit                 neg;
        na = op.num_a;
        da = op.den_a;
        nb = op.num_b;
        db = op.den_b;
        r.num = '0;
        r.den = '0;
        r.err = 1'b0;
        if (da == 0 || db == 0 || (op.mode == MODE_DIV && nb == 0))
        begin
            r.err = 1'b1;
            return r;
        end
        case (op.mode)
            MODE_ADD:
            begin
                n = na * db + nb * da;
                d = da * db;
            end
            MODE_SUB:
            begin
                n = na * db - nb * da;
                d = da * db;
            end
            MODE_MUL:
            begin
                n = na * nb;
                d = da * db;
            end
            default:
            begin
                n = na * db;
                d = da * nb;
            end
        endcase
        un = (n < 0) ? -n : n;
        ud = (d < 0) ? -d : d;
        if (un == 0)
        begin
            r.den = 32'd1;
            return r;
        end
        neg = (n < 0) != (d < 0);
        x = un;
        y = ud;
        while (y != 0)
        begin
            t = x % y;
            x = y;
            y = t;
        end
        qn = un / x;
        qd = ud / x;
        if (neg)
            qn = -qn;
        r.num = qn[31:0];
        r.den = qd[31:0];
        return r;
    endfunction

    // operand mix: full range, small values around zero, and the edges
    function automatic logic [OPW-1:0] pick_operand();
        int sel;
        sel = $urandom_range(0, 19);
        if (sel < 9)
            return OPW'($urandom);
        if (sel < 16)
            return OPW'(int'($urandom_range(0, 40)) - 20);
        case ($urandom_range(0, 5))
            0: return OPW'(MIN_OP);
            1: return OPW'(MAX_OP);
            2: return OPW'(MIN_OP + 1);
            3: return OPW'(-1);
            4: return OPW'(1);
            default: return '0;
        endcase
    endfunction

    task automatic queue_op(logic [1:0] m, int na, int da, int nb, int db);
        frac_op_t op;
        op.mode  = m;
        op.num_a = OPW'(na);
        op.den_a = OPW'(da);
        op.num_b = OPW'(nb);
        op.den_b = OPW'(db);
        pending_ops.push_back(op);
    endtask

    task automatic queue_random(int count);
        frac_op_t op;
        for (int i = 0; i < count; i++)
        begin
            op.mode  = 2'($urandom_range(0, 3));
            op.num_a = pick_operand();
            op.den_a = pick_operand();
            op.num_b = pick_operand();
            op.den_b = pick_operand();
            pending_ops.push_back(op);
        end
    endtask

    // sender holds back until every beat is out and every result has come
    task automatic wait_drained();
        @(negedge clk);
        while (pending_ops.size() != 0 || in_valid || reduced_q.size() != 0)
            @(negedge clk);
    endtask

    // input driver: predicts each accepted beat, then offers the next one
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            gap_left <= 0;
        end
        else
        begin
            if (in_valid && !in_stall)
                reduced_q.push_back(reduce_fraction('{mode, num_a, den_a, num_b, den_b}));
            if (!in_valid || !in_stall)
            begin
                if (gap_left > 0)
                begin
                    gap_left <= gap_left - 1;
                    in_valid <= 1'b0;
                end
                else if (pending_ops.size() != 0)
                begin
                    if (!calm && $urandom_range(0, 4) == 0)
                    begin
                        gap_left <= $urandom_range(1, 9) - 1;
                        in_valid <= 1'b0;
                    end
                    else
                    begin
                        next_op = pending_ops.pop_front();
                        mode     <= next_op.mode;
                        num_a    <= next_op.num_a;
                        den_a    <= next_op.den_a;
                        num_b    <= next_op.num_b;
                        den_b    <= next_op.den_b;
                        in_valid <= 1'b1;
                    end
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // output monitor: checks each result beat, then picks the next stall
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall    <= 1'b0;
            hold_left    <= 0;
            holds_served <= 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (reduced_q.size() == 0)
                begin
                    $display("%0t: result with none pending: num %0d den %0d err %0b",
                             $time, res_num, res_den, err);
                    mismatches++;
                end
                else
                begin
                    want = reduced_q.pop_front();
                    if (res_num !== want.num)
                    begin
                        $display("%0t: res_num expected %0d actual %0d",
                                 $time, want.num, res_num);
                        mismatches++;
                    end
                    if (res_den !== want.den)
                    begin
                        $display("%0t: res_den expected %0d actual %0d",
                                 $time, want.den, res_den);
                        mismatches++;
                    end
                    if (err !== want.err)
                    begin
                        $display("%0t: err expected %0b actual %0b",
                                 $time, want.err, err);
                        mismatches++;
                    end
                end
            end
            if (hold_left > 0)
            begin
                hold_left <= hold_left - 1;
                out_stall <= 1'b1;
            end
            else if (holds_asked != holds_served)
            begin
                holds_served <= holds_served + 1;
                hold_left    <= LONG_HOLD - 1;
                out_stall    <= 1'b1;
            end
            else if (!calm && $urandom_range(0, 5) == 0)
            begin
                hold_left <= $urandom_range(1, 9) - 1;
                out_stall <= 1'b1;
            end
            else
            begin
                out_stall <= 1'b0;
            end
        end
    end

    // run limit, several times the slowest correct run
    initial
    begin
        #10_000_000;
        $display("TEST FAILED");
        $finish;
    end

    // stimulus phases
    initial
    begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // directed: every operation, edges, errors, zero and whole results
        @(negedge clk);
        queue_op(MODE_ADD, 1, 2, 1, 3);
        queue_op(MODE_SUB, 1, 2, 1, 2);
        queue_op(MODE_MUL, 6, 3, 1, 1);
        queue_op(MODE_DIV, 1, 2, 1, 4);
        queue_op(MODE_ADD, 1, 0, 1, 1);
        queue_op(MODE_SUB, 1, 1, 1, 0);
        queue_op(MODE_MUL, 0, 0, 0, 0);
        queue_op(MODE_DIV, 3, 4, 0, 5);
        queue_op(MODE_DIV, 0, 7, 0, 0);
        queue_op(MODE_MUL, MIN_OP, 1, MIN_OP, 1);
        queue_op(MODE_ADD, MIN_OP, -1, MIN_OP, -1);
        queue_op(MODE_SUB, MIN_OP, MAX_OP, MAX_OP, MIN_OP);
        queue_op(MODE_MUL, MAX_OP, MIN_OP, MAX_OP, MIN_OP);
        queue_op(MODE_DIV, MIN_OP, MAX_OP, MAX_OP, MIN_OP);
        queue_op(MODE_ADD, -1, -1, -1, -1);
        queue_op(MODE_SUB, -3, 4, 5, -6);
        queue_op(MODE_MUL, -2, 3, 3, 2);
        queue_op(MODE_DIV, 5, -7, -2, 3);
        queue_op(MODE_ADD, 0, -5, 0, 9);
        queue_op(MODE_DIV, MAX_OP, 1, -1, MIN_OP);
        queue_op(MODE_ADD, MAX_OP, 1, MAX_OP, 1);
        queue_op(MODE_ADD, MIN_OP, MIN_OP, MIN_OP, MIN_OP);
        queue_op(MODE_DIV, 12, -8, -9, 6);
        queue_op(MODE_MUL, -1, MIN_OP, MIN_OP, -1);
        wait_drained();

        // random traffic with idling on both sides
        queue_random(480);
        wait_drained();

        // long receiver hold while the sender keeps offering beats
        holds_asked = holds_asked + 1;
        queue_random(16);
        wait_drained();

        // more random traffic, the last part without any idling
        queue_random(340);
        wait_drained();
        calm = 1'b1;
        queue_random(200);
        wait_drained();

        repeat (TAIL_WAIT) @(posedge clk);
        if (mismatches == 0 && reduced_q.size() == 0)
        begin
            $display("TEST PASSED");
        end
        else
        begin
            if (reduced_q.size() != 0)
                $display("%0t: %0d results never arrived", $time, reduced_q.size());
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
